// ===== rtl/zrbd_pkg.sv =====
// shared constants and types for the zero-run bitmap decoder
package zrbd_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 13;
    localparam int BITSEL_W = 3;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  count_t;

    localparam cmd_t CMD_BEGIN = 2'd0;
    localparam cmd_t CMD_BYTE  = 2'd1;
    localparam cmd_t CMD_FILL  = 2'd2;
    localparam cmd_t CMD_QUERY = 2'd3;

    localparam byte_t CLEAR_BYTE = 8'h00;
    localparam byte_t FILL_BYTE  = 8'hff;

    localparam count_t COUNT_RESET = 13'd1;

endpackage

// ===== rtl/zrbd_row_store.sv =====
// row byte store: one write port, one read port with registered data
module zrbd_row_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  zrbd_pkg::byte_t       wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output zrbd_pkg::byte_t       rd_data
);

    zrbd_pkg::byte_t mem [DEPTH];
    zrbd_pkg::byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/zero_run_bitmap_decoder.sv =====
// zero-run bitmap decoder: a query passes from accept through the pending stage to the output register
// bytes and queries are taken one per cycle while in_stall is low; begin and fill sweep the whole byte store,
// holding the input off while the sweep runs
// after reset the same sweep clears the store: the input is stalled until it ends
// reset is asynchronous, active low; the cluster limit resets to 1, write position to 0
// a query waits in one stage for the read data, then in the output register
module zero_run_bitmap_decoder #(
    parameter int MAX_CLUSTERS = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  zrbd_pkg::count_t        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  zrbd_pkg::cmd_t          cmd,
    input  zrbd_pkg::byte_t         data_byte,
    input  zrbd_pkg::count_t        cluster,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    visible
);

    localparam int STORE_BYTES = (MAX_CLUSTERS + 7) / 8;
    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PW  = $clog2(STORE_BYTES + 1);
    localparam int MCW = $clog2(MAX_CLUSTERS + 1);
    localparam int XW  = (MCW > zrbd_pkg::CNT_W) ? MCW : zrbd_pkg::CNT_W;
    localparam int SW  = ((PW > zrbd_pkg::BYTE_W) ? PW : zrbd_pkg::BYTE_W) + 1;

    zrbd_pkg::count_t   count_reg;
    logic [PW-1:0]      wpos_reg, wpos_next;
    logic               expect_reg, expect_next;
    logic               sweep_reg, sweep_next;
    logic               sweep_fill_reg, sweep_fill_next;
    logic [AW-1:0]      sweep_addr_reg, sweep_addr_next;
    logic               pend_reg, pend_next;
    logic               pend_hit_reg;
    logic [zrbd_pkg::BITSEL_W-1:0] pend_bit_reg;
    logic               out_valid_reg, out_valid_next;
    logic               visible_reg;

    logic [XW-1:0]      cnt_ext, eff;
    logic [XW:0]        eff_round;
    logic [PW-1:0]      len;
    logic [SW-1:0]      skip_sum;
    logic               accept, pend_move;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    zrbd_pkg::byte_t    wr_data;
    zrbd_pkg::byte_t    rd_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               in_range;

    assign cfg_ready = 1'b1;

    // effective cluster count and row length in bytes
    always_comb
    begin
        cnt_ext = XW'(count_reg);
        if (cnt_ext == '0)
        begin
            eff = XW'(1);
        end
        else if (cnt_ext > XW'(MAX_CLUSTERS))
        begin
            eff = XW'(MAX_CLUSTERS);
        end
        else
        begin
            eff = cnt_ext;
        end
        eff_round = {1'b0, eff} + (XW + 1)'(7);
        len = PW'(eff_round >> 3);
    end

    assign pend_move = pend_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = sweep_reg || (pend_reg && out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;

    assign skip_sum = SW'(wpos_reg) + SW'(data_byte);
    assign in_range = XW'(cluster) < eff;
    assign rd_en    = accept && (cmd == zrbd_pkg::CMD_QUERY);
    assign rd_addr  = AW'(cluster >> zrbd_pkg::BITSEL_W);

    always_comb
    begin
        wpos_next       = wpos_reg;
        expect_next     = expect_reg;
        sweep_next      = sweep_reg;
        sweep_fill_next = sweep_fill_reg;
        sweep_addr_next = sweep_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = wpos_reg[AW-1:0];
        wr_data         = data_byte;

        if (sweep_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_addr_reg;
            wr_data = sweep_fill_reg ? zrbd_pkg::FILL_BYTE : zrbd_pkg::CLEAR_BYTE;
            sweep_addr_next = sweep_addr_reg + AW'(1);
            if (sweep_addr_reg == AW'(STORE_BYTES - 1))
            begin
                sweep_next = 1'b0;
            end
        end
        else if (accept)
        begin
            case (cmd)
                zrbd_pkg::CMD_BEGIN:
                begin
                    wpos_next       = '0;
                    expect_next     = 1'b0;
                    sweep_next      = 1'b1;
                    sweep_fill_next = 1'b0;
                    sweep_addr_next = '0;
                end
                zrbd_pkg::CMD_BYTE:
                begin
                    if (expect_reg)
                    begin
                        expect_next = 1'b0;
                        // skip count saturates at the row end
                        if (skip_sum > SW'(len))
                        begin
                            wpos_next = len;
                        end
                        else
                        begin
                            wpos_next = PW'(skip_sum);
                        end
                    end
                    else if (wpos_reg < len)
                    begin
                        if (data_byte != zrbd_pkg::CLEAR_BYTE)
                        begin
                            wr_en     = 1'b1;
                            wpos_next = wpos_reg + PW'(1);
                        end
                        else
                        begin
                            expect_next = 1'b1;
                        end
                    end
                end
                zrbd_pkg::CMD_FILL:
                begin
                    wpos_next       = PW'(STORE_BYTES);
                    expect_next     = 1'b0;
                    sweep_next      = 1'b1;
                    sweep_fill_next = 1'b1;
                    sweep_addr_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pend_next = rd_en || (pend_reg && !pend_move);
        if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= zrbd_pkg::COUNT_RESET;
            wpos_reg       <= '0;
            expect_reg     <= 1'b0;
            sweep_reg      <= 1'b1;
            sweep_fill_reg <= 1'b0;
            sweep_addr_reg <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            wpos_reg       <= wpos_next;
            expect_reg     <= expect_next;
            sweep_reg      <= sweep_next;
            sweep_fill_reg <= sweep_fill_next;
            sweep_addr_reg <= sweep_addr_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pend_hit_reg <= in_range;
            pend_bit_reg <= cluster[zrbd_pkg::BITSEL_W-1:0];
        end
        if (pend_move)
        begin
            visible_reg <= pend_hit_reg && rd_data[pend_bit_reg];
        end
    end

    zrbd_row_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the zero-run bitmap decoder
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_CLUSTERS  = 4096;
    localparam int STORE_BYTES   = (MAX_CLUSTERS + 7) / 8;
    localparam int SETTLE_CYCLES = STORE_BYTES + 88;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DIRECTED_ROWS = 29;

    typedef struct packed {
        logic             is_cfg;
        zrbd_pkg::count_t cfg_value;
        zrbd_pkg::cmd_t   op;
        zrbd_pkg::byte_t  data;
        zrbd_pkg::count_t cl;
        logic             lit_on;
        logic             lit_val;
    } dir_row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    zrbd_pkg::count_t cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    zrbd_pkg::cmd_t   cmd       = zrbd_pkg::CMD_BEGIN;
    zrbd_pkg::byte_t  data_byte = '0;
    zrbd_pkg::count_t cluster   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             visible;

    // shadow copy of the decoder state
    zrbd_pkg::byte_t  shadow_row [STORE_BYTES];
    int               shadow_wpos;
    bit               shadow_skip_pending;
    zrbd_pkg::count_t shadow_count;

    logic   visible_due [$];
    int     error_count   = 0;
    int     requests_sent = 0;
    int     cycle_count   = 0;
    bit     calm          = 1'b0;

    dir_row_t directed_rows [DIRECTED_ROWS];

    zero_run_bitmap_decoder #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .data_byte (data_byte),
        .cluster   (cluster),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .visible   (visible)
    );

    always #5 clk = ~clk;

    function automatic zrbd_pkg::byte_t rand_byte(input int unsigned hi, input int unsigned lo);
        return zrbd_pkg::byte_t'($urandom_range(hi, lo));
    endfunction

    function automatic zrbd_pkg::count_t rand_cl(input int unsigned hi, input int unsigned lo);
        return zrbd_pkg::count_t'($urandom_range(hi, lo));
    endfunction

    function automatic int clamped_count();
        int n;
        n = int'(shadow_count);
        if (n == 0)
            n = 1;
        if (n > MAX_CLUSTERS)
            n = MAX_CLUSTERS;
        return n;
    endfunction

    // advance the shadow state by one request; returns 1 when a query answers
    function automatic bit decode_step(input zrbd_pkg::cmd_t op, input zrbd_pkg::byte_t b,
                                       input zrbd_pkg::count_t cl, output logic vis);
        int len;
        len = (clamped_count() + 7) / 8;
        vis = 1'b0;
        case (op)
            zrbd_pkg::CMD_BEGIN:
            begin
                foreach (shadow_row[i])
                    shadow_row[i] = zrbd_pkg::CLEAR_BYTE;
                shadow_wpos = 0;
                shadow_skip_pending = 1'b0;
                return 1'b0;
            end
            zrbd_pkg::CMD_BYTE:
            begin
                if (shadow_skip_pending)
                begin
                    shadow_skip_pending = 1'b0;
                    shadow_wpos += int'(b);
                    if (shadow_wpos > len)
                        shadow_wpos = len;
                end
                else if (shadow_wpos < len)
                begin
                    if (b != zrbd_pkg::CLEAR_BYTE)
                    begin
                        shadow_row[shadow_wpos] = b;
                        shadow_wpos++;
                    end
                    else
                        shadow_skip_pending = 1'b1;
                end
                return 1'b0;
            end
            zrbd_pkg::CMD_FILL:
            begin
                foreach (shadow_row[i])
                    shadow_row[i] = zrbd_pkg::FILL_BYTE;
                shadow_wpos = STORE_BYTES;
                shadow_skip_pending = 1'b0;
                return 1'b0;
            end
            default:
            begin
                if (int'(cl) < clamped_count())
                    vis = shadow_row[cl >> 3][cl[2:0]];
                return 1'b1;
            end
        endcase
    endfunction

    task automatic send_request(input zrbd_pkg::cmd_t op, input zrbd_pkg::byte_t b,
                                input zrbd_pkg::count_t cl,
                                input logic lit_on, input logic lit_val);
        logic vis;
        while (!calm && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        data_byte <= b;
        cluster   <= cl;
        do
            @(posedge clk);
        while (in_stall);
        if (decode_step(op, b, cl, vis))
            visible_due.push_back(lit_on ? lit_val : vis);
        requests_sent++;
    endtask

    // stop sending, let every answer come back and any sweep finish
    task automatic hold_until_idle();
        in_valid <= 1'b0;
        while (visible_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cluster_limit(input zrbd_pkg::count_t value);
        hold_until_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_count = value;
    endtask

    // one compressed row: mostly well formed, with stray queries, restarts and fills
    task automatic random_row(input bit do_begin);
        int               len;
        int               eff;
        int               pos;
        int               r;
        int               skip;
        int               n;
        zrbd_pkg::count_t q_cl;
        eff = clamped_count();
        len = (eff + 7) / 8;
        if (do_begin)
            send_request(zrbd_pkg::CMD_BEGIN, rand_byte(255, 0), rand_cl(8191, 0),
                         1'b0, 1'b0);
        pos = 0;
        while (pos < len)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send_request(zrbd_pkg::CMD_QUERY, rand_byte(255, 0), rand_cl(eff - 1, 0),
                             1'b0, 1'b0);
            else if (r < 10)
            begin
                send_request(zrbd_pkg::CMD_BEGIN, rand_byte(255, 0), rand_cl(8191, 0),
                             1'b0, 1'b0);
                pos = 0;
            end
            else if (r < 11)
            begin
                send_request(zrbd_pkg::CMD_FILL, rand_byte(255, 0), rand_cl(8191, 0),
                             1'b0, 1'b0);
                pos = len;
            end
            else if (r < ((len > 64) ? 55 : 30))
            begin
                skip = (len > 64) ? $urandom_range(255) : $urandom_range(len);
                send_request(zrbd_pkg::CMD_BYTE, zrbd_pkg::CLEAR_BYTE, rand_cl(8191, 0),
                             1'b0, 1'b0);
                send_request(zrbd_pkg::CMD_BYTE, zrbd_pkg::byte_t'(skip), rand_cl(8191, 0),
                             1'b0, 1'b0);
                pos += skip;
            end
            else
            begin
                send_request(zrbd_pkg::CMD_BYTE, rand_byte(255, 1), rand_cl(8191, 0),
                             1'b0, 1'b0);
                pos++;
            end
        end
        // bytes past the end of the row, a trailing zero now and then
        n = $urandom_range(3);
        repeat (n)
            send_request(zrbd_pkg::CMD_BYTE, rand_byte(255, 0), rand_cl(8191, 0),
                         1'b0, 1'b0);
        n = $urandom_range(12, 4);
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 70)
                q_cl = rand_cl(eff - 1, 0);
            else if (r < 85)
                q_cl = rand_cl(8191, eff);
            else
                q_cl = rand_cl(8191, 0);
            send_request(zrbd_pkg::CMD_QUERY, rand_byte(255, 0), q_cl, 1'b0, 1'b0);
        end
    endtask

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 25);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (visible_due.size() == 0)
            begin
                $display("%0t: result with no query waiting, expected none actual %0b",
                         $time, visible);
                error_count++;
            end
            else if (visible !== visible_due[0])
            begin
                $display("%0t: visible mismatch, expected %0b actual %0b",
                         $time, visible_due[0], visible);
                error_count++;
                void'(visible_due.pop_front());
            end
            else
                void'(visible_due.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int               phase;
        int               rows;
        int               r;
        zrbd_pkg::count_t new_count;

        directed_rows = '{
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd0,    1'b1, 1'b0}, // store clear
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd8191, 1'b1, 1'b0}, // far out
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'hff, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd0,    1'b1, 1'b1},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h01, 13'd0,    1'b0, 1'b0}, // row full
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd1,    1'b1, 1'b0},
            '{1'b1, 13'd4096, zrbd_pkg::CMD_BEGIN, 8'h00, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BEGIN, 8'h00, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h00, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'hff, 13'd0,    1'b0, 1'b0}, // skip 255
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h80, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd2047, 1'b1, 1'b1},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd2046, 1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h00, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'hff, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h00, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h05, 13'd0,    1'b0, 1'b0}, // past end
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h7f, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd4095, 1'b1, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd4096, 1'b1, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BEGIN, 8'h00, 13'd0,    1'b0, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd2047, 1'b1, 1'b0},
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h00, 13'd0,    1'b0, 1'b0}, // pending
            '{1'b0, 13'd0,    zrbd_pkg::CMD_FILL,  8'h00, 13'd0,    1'b0, 1'b0}, // drops it
            '{1'b0, 13'd0,    zrbd_pkg::CMD_BYTE,  8'h12, 13'd0,    1'b0, 1'b0},
            '{1'b1, 13'd0,    zrbd_pkg::CMD_BEGIN, 8'h00, 13'd0,    1'b0, 1'b0}, // zero is one
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd1,    1'b1, 1'b0},
            '{1'b1, 13'd8191, zrbd_pkg::CMD_BEGIN, 8'h00, 13'd0,    1'b0, 1'b0}, // clamps
            '{1'b0, 13'd0,    zrbd_pkg::CMD_QUERY, 8'h00, 13'd4095, 1'b1, 1'b1}
        };

        foreach (shadow_row[i])
            shadow_row[i] = zrbd_pkg::CLEAR_BYTE;
        shadow_wpos = 0;
        shadow_skip_pending = 1'b0;
        shadow_count = zrbd_pkg::COUNT_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_cluster_limit(directed_rows[i].cfg_value);
            else
                send_request(directed_rows[i].op, directed_rows[i].data, directed_rows[i].cl,
                             directed_rows[i].lit_on, directed_rows[i].lit_val);
        end

        phase = 0;
        rows = requests_sent + RANDOM_ITEMS;
        while (requests_sent < rows)
        begin
            // a few phases run with both sides flat out
            calm = (phase >= 4 && phase < 7);
            r = $urandom_range(19);
            case (r)
                0:       new_count = 13'd0;
                1:       new_count = 13'd8191;
                2:       new_count = zrbd_pkg::count_t'(MAX_CLUSTERS);
                3:       new_count = rand_cl(8190, MAX_CLUSTERS + 1);
                4:       new_count = zrbd_pkg::COUNT_RESET;
                5, 6:    new_count = rand_cl(700, 65);
                default: new_count = rand_cl(64, 1);
            endcase
            write_cluster_limit(new_count);
            r = $urandom_range(4, 1);
            // sometimes keep decoding the old row under the new length
            random_row($urandom_range(3) != 0);
            repeat (r - 1)
                random_row(1'b1);
            phase++;
        end
        calm = 1'b0;

        hold_until_idle();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
